@@ rtl/core/mlxd_pkg.sv @@
`default_nettype none

package mlxd_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 16;
   localparam int CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_MAGIC  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_MAGIC = 8'd1;

   localparam logic [BYTE_W-1:0] FIRST_MAGIC_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] SECOND_MAGIC_RESET = 8'h55;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] first_magic;
      logic [BYTE_W-1:0] second_magic;
   } magic_type;

   typedef struct packed {
      logic              item_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_good;
      logic [LEN_W-1:0]  frame_length;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/core/mlxd_intf.sv @@
`default_nettype none

interface mlxd_req_if
   import mlxd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mlxd_rsp_if
   import mlxd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              item_kind;
   logic [BYTE_W-1:0] payload_byte;
   logic              frame_good;
   logic [LEN_W-1:0]  frame_length;

   modport source (output valid, output item_kind, output payload_byte,
                   output frame_good, output frame_length, input ready);
   modport sink   (input valid, input item_kind, input payload_byte,
                   input frame_good, input frame_length, output ready);
endinterface

interface mlxd_csr_if
   import mlxd_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [BYTE_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mlxd_csr.sv @@
`default_nettype none

module mlxd_csr
   import mlxd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mlxd_csr_if.sink   csr_if,
   output magic_type  magic
);

   logic [BYTE_W-1:0] first_magic_ff;
   logic [BYTE_W-1:0] first_magic_in;
   logic [BYTE_W-1:0] second_magic_ff;
   logic [BYTE_W-1:0] second_magic_in;
   logic              wr;

   assign csr_if.ready = 1'b1;
   assign wr = csr_if.valid && csr_if.ready;

   always_comb begin
      first_magic_in  = first_magic_ff;
      second_magic_in = second_magic_ff;
      if (wr) begin
         case (csr_if.index)
            CSR_FIRST_MAGIC:  first_magic_in  = csr_if.data;
            CSR_SECOND_MAGIC: second_magic_in = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_magic_ff  <= FIRST_MAGIC_RESET;
         second_magic_ff <= SECOND_MAGIC_RESET;
      end else begin
         first_magic_ff  <= first_magic_in;
         second_magic_ff <= second_magic_in;
      end
   end

   assign magic.first_magic  = first_magic_ff;
   assign magic.second_magic = second_magic_ff;

endmodule

`default_nettype wire

@@ rtl/core/mlxd_parser.sv @@
`default_nettype none

module mlxd_parser
   import mlxd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire magic_type magic,
   mlxd_req_if.sink   req_if,
   mlxd_rsp_if.source rsp_if
);

   localparam logic [2:0] PH_HUNT1   = 3'd0;
   localparam logic [2:0] PH_HUNT2   = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_LEN_LO  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CHECK   = 3'd5;

   logic [2:0]        phase_ff;
   logic [2:0]        phase_in;
   logic [BYTE_W-1:0] len_hi_ff;
   logic [BYTE_W-1:0] len_hi_in;
   logic [LEN_W-1:0]  exp_len_ff;
   logic [LEN_W-1:0]  exp_len_in;
   logic [LEN_W-1:0]  seen_ff;
   logic [LEN_W-1:0]  seen_in;
   logic [BYTE_W-1:0] xor_ff;
   logic [BYTE_W-1:0] xor_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_word_type      rsp_word_ff;
   rsp_word_type      rsp_word_in;

   logic              take;
   logic              has_rsp;
   logic [BYTE_W-1:0] b;
   logic [LEN_W-1:0]  new_len;

   assign b       = req_if.data_byte;
   assign new_len = {len_hi_ff, b};

   // one output stage: a new word may enter as the held one leaves
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      phase_in    = phase_ff;
      len_hi_in   = len_hi_ff;
      exp_len_in  = exp_len_ff;
      seen_in     = seen_ff;
      xor_in      = xor_ff;
      has_rsp     = 1'b0;
      rsp_word_in = '0;
      case (phase_ff)
         PH_HUNT2: begin
            if (b == magic.second_magic) begin
               phase_in = PH_LEN_HI;
            end else if (b != magic.first_magic) begin
               phase_in = PH_HUNT1;
            end
         end
         PH_LEN_HI: begin
            len_hi_in = b;
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            exp_len_in = new_len;
            seen_in    = '0;
            xor_in     = '0;
            phase_in   = (new_len == '0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            xor_in  = xor_ff ^ b;
            seen_in = seen_ff + LEN_W'(1);
            if (seen_in >= exp_len_ff) begin
               phase_in = PH_CHECK;
            end
            has_rsp                  = 1'b1;
            rsp_word_in.item_kind    = KIND_PAYLOAD;
            rsp_word_in.payload_byte = b;
         end
         PH_CHECK: begin
            has_rsp                  = 1'b1;
            rsp_word_in.item_kind    = KIND_END;
            rsp_word_in.frame_good   = (xor_ff == b);
            rsp_word_in.frame_length = exp_len_ff;
            phase_in   = PH_HUNT1;
            len_hi_in  = '0;
            exp_len_in = '0;
            seen_in    = '0;
            xor_in     = '0;
         end
         default: begin
            phase_in = (b == magic.first_magic) ? PH_HUNT2 : PH_HUNT1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (take && has_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT1;
         len_hi_ff    <= '0;
         exp_len_ff   <= '0;
         seen_ff      <= '0;
         xor_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff   <= phase_in;
            len_hi_ff  <= len_hi_in;
            exp_len_ff <= exp_len_in;
            seen_ff    <= seen_in;
            xor_ff     <= xor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && has_rsp) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.item_kind    = rsp_word_ff.item_kind;
   assign rsp_if.payload_byte = rsp_word_ff.payload_byte;
   assign rsp_if.frame_good   = rsp_word_ff.frame_good;
   assign rsp_if.frame_length = rsp_word_ff.frame_length;

`ifndef ASSERT_OFF
   a_check_ends_frame: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_CHECK |=>
         phase_ff == PH_HUNT1 && rsp_valid_ff && rsp_word_ff.item_kind == KIND_END)
      else $error("checksum word did not close the frame");

   a_payload_forwarded: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_PAYLOAD |=>
         rsp_valid_ff && rsp_word_ff.item_kind == KIND_PAYLOAD
         && rsp_word_ff.payload_byte == $past(b))
      else $error("payload word not forwarded");

   a_no_word_outside_frame: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff != PH_PAYLOAD && phase_ff != PH_CHECK |=>
         rsp_valid_ff == ($past(rsp_valid_ff) && !$past(rsp_if.ready)))
      else $error("result produced outside payload or checksum");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> seen_ff < exp_len_ff)
      else $error("payload count passed frame length");
`endif

endmodule

`default_nettype wire

@@ rtl/core/magic_length_xor_deframer_unit.sv @@
// Byte-stream deframer for magic / length / XOR-checksum frames.
// req_if carries one received byte per word. A frame is first_magic,
// second_magic, a big-endian 16-bit length, that many payload bytes and a
// checksum byte equal to the XOR of the payload.
// rsp_if carries one word per payload byte (item_kind 0) and one end word
// per frame (item_kind 1) with frame_good and frame_length. Bytes outside a
// frame produce nothing. Consumers drop frames not marked good.
// csr_if writes the marker bytes: index 0 first_magic, index 1
// second_magic; other indexes are ignored. csr_if.ready is always high.
// A result appears on rsp_if in the cycle after its byte is taken.
// Throughput: one byte per cycle, set by the single output register; a new
// byte is taken in the same cycle the held result leaves.
// When rsp_if stalls, the result is held and req_if.ready drops until it
// is taken.
// Reset (synchronous, active high) returns to hunting the first marker
// byte, drops any held result and restores markers 0xAA and 0x55.
`default_nettype none

module magic_length_xor_deframer_unit
   import mlxd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mlxd_req_if.sink   req_if,
   mlxd_rsp_if.source rsp_if,
   mlxd_csr_if.sink   csr_if
);

   magic_type magic;

   mlxd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .magic  (magic)
   );

   mlxd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .magic  (magic),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

@@ bench/magic_length_xor_deframer_unit_tb.sv @@
`timescale 1ns / 1ps

import mlxd_pkg::*;

typedef enum logic [2:0] {
   HUNT_FIRST  = 3'd0,
   HUNT_SECOND = 3'd1,
   LEN_HIGH    = 3'd2,
   LEN_LOW     = 3'd3,
   IN_PAYLOAD  = 3'd4,
   AT_CHECKSUM = 3'd5
} deframe_phase_type;

class deframe_scoreboard;
   logic [BYTE_W-1:0] first_magic;
   logic [BYTE_W-1:0] second_magic;
   deframe_phase_type phase;
   logic [BYTE_W-1:0] len_high;
   logic [LEN_W-1:0]  frame_len;
   logic [LEN_W-1:0]  bytes_seen;
   logic [BYTE_W-1:0] xor_acc;
   rsp_word_type      expected_words[$];
   int unsigned       mismatches;

   function new();
      first_magic  = FIRST_MAGIC_RESET;
      second_magic = SECOND_MAGIC_RESET;
      mismatches   = 0;
      clear_frame();
   endfunction

   function void clear_frame();
      phase      = HUNT_FIRST;
      len_high   = '0;
      frame_len  = '0;
      bytes_seen = '0;
      xor_acc    = '0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [BYTE_W-1:0] value);
      if (idx == CSR_FIRST_MAGIC) begin
         first_magic = value;
      end else if (idx == CSR_SECOND_MAGIC) begin
         second_magic = value;
      end
   endfunction

   function void note_byte(logic [BYTE_W-1:0] b);
      rsp_word_type w;
      w = '0;
      case (phase)
         HUNT_SECOND: begin
            if (b == second_magic) begin
               phase = LEN_HIGH;
            end else if (b != first_magic) begin
               phase = HUNT_FIRST;
            end
         end
         LEN_HIGH: begin
            len_high = b;
            phase    = LEN_LOW;
         end
         LEN_LOW: begin
            frame_len  = {len_high, b};
            bytes_seen = '0;
            xor_acc    = '0;
            phase      = (frame_len == '0) ? AT_CHECKSUM : IN_PAYLOAD;
         end
         IN_PAYLOAD: begin
            xor_acc    = xor_acc ^ b;
            bytes_seen = bytes_seen + 1'b1;
            if (bytes_seen >= frame_len) begin
               phase = AT_CHECKSUM;
            end
            w.item_kind    = KIND_PAYLOAD;
            w.payload_byte = b;
            expected_words.push_back(w);
         end
         AT_CHECKSUM: begin
            w.item_kind    = KIND_END;
            w.frame_good   = (xor_acc == b);
            w.frame_length = frame_len;
            expected_words.push_back(w);
            clear_frame();
         end
         default: begin
            phase = (b == first_magic) ? HUNT_SECOND : HUNT_FIRST;
         end
      endcase
   endfunction

   function void check_word(rsp_word_type got);
      rsp_word_type want;
      if (expected_words.size() == 0) begin
         $error("rsp word with nothing expected: kind %0d byte %02h", got.item_kind,
                got.payload_byte);
         mismatches++;
         return;
      end
      want = expected_words.pop_front();
      if (got.item_kind !== want.item_kind) begin
         $error("item_kind: expected %0d, got %0d", want.item_kind, got.item_kind);
         mismatches++;
      end
      if (got.payload_byte !== want.payload_byte) begin
         $error("payload_byte: expected %02h, got %02h", want.payload_byte, got.payload_byte);
         mismatches++;
      end
      if (got.frame_good !== want.frame_good) begin
         $error("frame_good: expected %0d, got %0d", want.frame_good, got.frame_good);
         mismatches++;
      end
      if (got.frame_length !== want.frame_length) begin
         $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
         mismatches++;
      end
   endfunction

   function int unsigned pending();
      return expected_words.size();
   endfunction
endclass

module magic_length_xor_deframer_unit_tb;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 8'd7;

   logic clock;
   logic reset;

   mlxd_req_if req_if();
   mlxd_rsp_if rsp_if();
   mlxd_csr_if csr_if();

   magic_length_xor_deframer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   deframe_scoreboard sb;
   logic [BYTE_W-1:0] stream_bytes[$];
   logic [BYTE_W-1:0] cur_first;
   logic [BYTE_W-1:0] cur_second;
   rsp_word_type      got_word;
   int unsigned       stall_count;
   int unsigned       stall_mode;

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver back-pressure, switching at random among four patterns
   always @(posedge clock) begin
      stall_count <= stall_count + 1;
      if (stall_count % 300 == 299) begin
         stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
         2: rsp_if.ready <= (stall_count % 4 != 0);
         default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            sb.write_reg(csr_if.index, csr_if.data);
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_byte(req_if.data_byte);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got_word.item_kind    = rsp_if.item_kind;
            got_word.payload_byte = rsp_if.payload_byte;
            got_word.frame_good   = rsp_if.frame_good;
            got_word.frame_length = rsp_if.frame_length;
            sb.check_word(got_word);
         end
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [BYTE_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == CSR_FIRST_MAGIC) begin
         cur_first = value;
      end else if (idx == CSR_SECOND_MAGIC) begin
         cur_second = value;
      end
   endtask

   task automatic send_byte(logic [BYTE_W-1:0] b);
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // bursts of random length; some bursts run back to back with no gap
   task automatic send_stream();
      int unsigned idx;
      int unsigned burst;
      idx = 0;
      while (idx < stream_bytes.size()) begin
         burst = $urandom_range(1, 32);
         while (burst != 0 && idx < stream_bytes.size()) begin
            send_byte(stream_bytes[idx]);
            idx++;
            burst--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_if.valid <= 1'b0;
      stream_bytes.delete();
   endtask

   task automatic drain();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void add_frame(logic [BYTE_W-1:0] m1, logic [BYTE_W-1:0] m2,
                                     logic [LEN_W-1:0] len, bit good,
                                     int unsigned extra_first);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] b;
      acc = '0;
      stream_bytes.push_back(m1);
      repeat (extra_first) stream_bytes.push_back(m1);
      stream_bytes.push_back(m2);
      stream_bytes.push_back(len[15:8]);
      stream_bytes.push_back(len[7:0]);
      for (int unsigned i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         acc = acc ^ b;
         stream_bytes.push_back(b);
      end
      stream_bytes.push_back(good ? acc : acc ^ 8'($urandom_range(1, 255)));
   endfunction

   // mostly well-formed frames, some noise and broken headers
   function automatic int unsigned add_random_mix();
      int unsigned pick;
      int unsigned before_size;
      logic [LEN_W-1:0] len;
      int unsigned extra;
      before_size = stream_bytes.size();
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
         case ($urandom_range(0, 19))
            0:       len = '0;
            1:       len = 16'($urandom_range(200, 300));
            2, 3, 4: len = 16'($urandom_range(13, 40));
            default: len = 16'($urandom_range(1, 12));
         endcase
         extra = (cur_first != cur_second && $urandom_range(0, 4) == 0) ?
                 $urandom_range(1, 3) : 0;
         add_frame(cur_first, cur_second, len, $urandom_range(0, 9) >= 3, extra);
         return stream_bytes.size() - before_size;
      end else if (pick == 7) begin
         repeat ($urandom_range(1, 5)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 8) begin
         stream_bytes.push_back(cur_first);
         stream_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         stream_bytes.push_back(cur_first);
         stream_bytes.push_back(cur_first);
         stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
      return 0;
   endfunction

   task automatic run_phase(logic [BYTE_W-1:0] m1, logic [BYTE_W-1:0] m2,
                            int unsigned target);
      int unsigned framed;
      write_csr(CSR_FIRST_MAGIC, m1);
      write_csr(CSR_SECOND_MAGIC, m2);
      framed = 0;
      while (framed < target) begin
         framed += add_random_mix();
      end
      send_stream();
      drain();
   endtask

   initial begin
      sb = new();
      cur_first  = FIRST_MAGIC_RESET;
      cur_second = SECOND_MAGIC_RESET;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= '0;
      csr_if.data      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset markers: noise, repeated first byte with zero length, false second
      // byte, one-byte frame, bad checksum, zero length with bad checksum
      stream_bytes = '{8'h00, 8'hFF,
                       8'hAA, 8'hAA, 8'h55, 8'h00, 8'h00, 8'h00,
                       8'hAA, 8'h12,
                       8'hAA, 8'h55, 8'h00, 8'h01, 8'hFF, 8'hFF,
                       8'hAA, 8'h55, 8'h00, 8'h02, 8'h00, 8'h80, 8'h7F,
                       8'hAA, 8'h55, 8'h00, 8'h00, 8'h01};
      send_stream();
      drain();

      write_csr(CSR_UNMAPPED, 8'h3C);
      run_phase(8'hAA, 8'h55, 140);
      run_phase(8'h00, 8'hFF, 140);
      run_phase(8'hFF, 8'h00, 140);
      run_phase(8'h3C, 8'h3C, 140);
      run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 140);
      run_phase(8'hFF, 8'hFF, 140);
      run_phase(8'h00, 8'h00, 140);

      // long frame with the high length byte set
      write_csr(CSR_FIRST_MAGIC, 8'h5A);
      write_csr(CSR_SECOND_MAGIC, 8'hA5);
      add_frame(cur_first, cur_second, 16'h0100, 1'b1, 0);
      add_frame(cur_first, cur_second, 16'h0003, 1'b0, 0);
      send_stream();
      drain();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/mlxd_pkg.sv
rtl/core/mlxd_intf.sv
rtl/core/mlxd_csr.sv
rtl/core/mlxd_parser.sv
rtl/core/magic_length_xor_deframer_unit.sv
bench/magic_length_xor_deframer_unit_tb.sv
